// File: rtl/core/hft_pkg.sv
// ----------------------------------------------------------------------------
// hft_pkg
// Types, character codes and the delimiter function shared by the header
// field tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hft_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } hft_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_field;
        logic       field_opens;
        logic       field_closes;
    } hft_out_t;

    typedef enum logic [2:0] {
        ST_SKIP    = 3'd0,
        ST_PLAIN   = 3'd1,
        ST_DQUOTE  = 3'd2,
        ST_ANGLE   = 3'd3,
        ST_COMMENT = 3'd4
    } scan_state_t;

    localparam logic [2:0] MODE_STD      = 3'd0;
    localparam logic [2:0] MODE_LIST     = 3'd1;
    localparam logic [2:0] MODE_SEMI     = 3'd2;
    localparam logic [2:0] MODE_SLASH    = 3'd3;
    localparam logic [2:0] MODE_WS       = 3'd4;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_LANGLE     = 8'h3C;
    localparam logic [7:0] CH_RANGLE     = 8'h3E;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_delim(input logic [2:0] mode, input logic [7:0] c);
        logic std_set;
        std_set = is_ws(c) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_EQUAL);
        case (mode)
            MODE_LIST:  return (c == CH_COMMA) || (c == CH_SEMI);
            MODE_SEMI:  return (c == CH_SEMI);
            MODE_SLASH: return std_set || (c == CH_SLASH);
            MODE_WS:    return is_ws(c);
            default:    return std_set;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hft_in_reg.sv
// ----------------------------------------------------------------------------
// hft_in_reg
// Input register: captures one word from the input channel and holds it until
// the scanner takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hft_in_reg
    import hft_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire hft_in_t s_data,
    input  wire logic    adv,
    output logic         item_valid,
    output hft_in_t      item
);

    logic    valid_reg;
    logic    valid_next;
    hft_in_t data_reg;

    assign s_ready    = !valid_reg || adv;
    assign valid_next = s_valid || (valid_reg && !adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hft_scanner.sv
// ----------------------------------------------------------------------------
// hft_scanner
// Scan state machine: classifies the held byte against the current state and
// delimiter mode, and advances the state when the word moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module hft_scanner
    import hft_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire hft_in_t    item,
    input  wire logic [2:0] mode,
    output hft_out_t        result
);

    scan_state_t state_reg;
    scan_state_t state_next;
    logic        esc_reg;
    logic        esc_next;

    logic [7:0]  c;
    logic        last;
    logic        delim;
    logic        quoting;
    logic [7:0]  closer;

    assign c       = item.in_byte;
    assign last    = item.end_of_string;
    assign delim   = is_delim(mode, c);
    assign quoting = (mode != MODE_WS);
    assign closer  = (state_reg == ST_DQUOTE) ? CH_DQUOTE : CH_RANGLE;

    always_comb begin
        state_next = state_reg;
        esc_next   = esc_reg;
        case (state_reg)
            ST_PLAIN: begin
                if (delim) begin
                    state_next = ST_SKIP;
                end
            end
            ST_DQUOTE, ST_ANGLE: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == closer) begin
                    state_next = ST_SKIP;
                end else if ((c == CH_BACKSLASH) && !last) begin
                    esc_next = 1'b1;
                end
            end
            ST_COMMENT: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == CH_RPAREN) begin
                    state_next = ST_SKIP;
                end else if ((c == CH_BACKSLASH) && !last) begin
                    esc_next = 1'b1;
                end
            end
            default: begin
                esc_next = 1'b0;
                if (delim) begin
                    state_next = ST_SKIP;
                end else if (quoting && (c == CH_DQUOTE)) begin
                    state_next = ST_DQUOTE;
                end else if (quoting && (c == CH_LANGLE)) begin
                    state_next = ST_ANGLE;
                end else if (quoting && (c == CH_LPAREN)) begin
                    state_next = ST_COMMENT;
                end else begin
                    state_next = ST_PLAIN;
                end
            end
        endcase
        if (last) begin
            state_next = ST_SKIP;
            esc_next   = 1'b0;
        end
    end

    always_comb begin
        result.out_byte     = c;
        result.in_field     = 1'b0;
        result.field_opens  = 1'b0;
        result.field_closes = 1'b0;
        case (state_reg)
            ST_PLAIN: begin
                if (delim) begin
                    result.field_closes = 1'b1;
                end else begin
                    result.in_field     = 1'b1;
                    result.field_closes = last;
                end
            end
            ST_DQUOTE, ST_ANGLE: begin
                if (!esc_reg && (c == closer)) begin
                    result.field_closes = 1'b1;
                end else begin
                    result.in_field     = 1'b1;
                    result.field_closes = last;
                end
            end
            ST_COMMENT: begin
                result.in_field = 1'b0;
            end
            default: begin
                if (!delim) begin
                    if (quoting && ((c == CH_DQUOTE) || (c == CH_LANGLE))) begin
                        result.field_opens  = 1'b1;
                        result.field_closes = last;
                    end else if (!(quoting && (c == CH_LPAREN))) begin
                        result.in_field     = 1'b1;
                        result.field_opens  = 1'b1;
                        result.field_closes = last;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SKIP;
            esc_reg   <= 1'b0;
        end else if (adv) begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
        end
    end

`ifndef SYNTH
    a_esc_only_quoted: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (state_reg == ST_DQUOTE || state_reg == ST_ANGLE
                     || state_reg == ST_COMMENT))
        else $error("escape pending outside quoted field or comment");

    a_last_returns_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item.end_of_string) |=> (state_reg == ST_SKIP && !esc_reg))
        else $error("state not back to skipping after end of string");

    a_opens_from_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        result.field_opens |-> (state_reg != ST_PLAIN && state_reg != ST_DQUOTE
                                && state_reg != ST_ANGLE && state_reg != ST_COMMENT))
        else $error("field opened while not skipping");

    a_escaped_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (result.in_field || state_reg == ST_COMMENT))
        else $error("escaped byte dropped from field");
`endif

endmodule

`default_nettype wire

// File: rtl/core/header_field_tokenizer.sv
// ----------------------------------------------------------------------------
// header_field_tokenizer
// Streaming header field tokenizer: marks each byte of a header string as part
// of a field and flags where fields open and close.
// ----------------------------------------------------------------------------
//  channel   ports                           payload
//  input     s_valid / s_ready / s_data      hft_in_t  (in_byte, end_of_string)
//  result    m_valid / m_ready / m_data      hft_out_t (out_byte, flags)
//  config    cfg_valid / cfg_ready / cfg_data delim_mode, 3 bits
//
//  One word per cycle sustained while m_ready is high; input and result are separated by two registers.
//  The input register feeds the scan state machine, whose result lands in the
//  output register in the same cycle as the state update.
//  Reset returns to skipping delimiters with delim_mode 0; no clearing pass.
//  A stalled result holds; the input register still takes a word while empty.
// ----------------------------------------------------------------------------
`default_nettype none

module header_field_tokenizer
    import hft_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire hft_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output hft_out_t        m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_data
);

    logic       item_valid;
    hft_in_t    item;
    logic       adv;
    hft_out_t   result;
    logic [2:0] mode_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    hft_out_t   out_data_reg;

    assign cfg_ready      = 1'b1;
    assign adv            = item_valid && (!out_valid_reg || m_ready);
    assign out_valid_next = adv || (out_valid_reg && !m_ready);

    hft_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    hft_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (item),
        .mode    (mode_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_STD;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
